### hdl/btsmp_pkg.sv
// Shared types, widths and constants for the Bezier trail sampler.
// Used by the cell, MAC and core modules; has no dependencies of its own.
package btsmp_pkg;

    localparam int DEF_HISTORY = 8;
    localparam int DEF_TRACE = 16;
    localparam logic [3:0] MIN_POINTS_RESET = 4'd2;

    // Widths of the weight recursion, the weight itself and the accumulators.
    localparam int XW = 50;
    localparam int WW = 34;
    localparam int AW = 72;

    localparam int U_ONE = 16384;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // One point pair: entries 0..2 are bottom x/y/z, 3..5 are top x/y/z.
    typedef logic [5:0][31:0] pair_t;

    typedef struct packed {
        logic shift;
        logic rotate;
        logic wload;
        logic wmul;
        logic wfin;
    } ctl_t;

    // Binomial coefficient from Pascal's triangle, for elaboration-time tables.
    function automatic longint binom(input int n, input int k);
        longint row [16];
        for (int i = 0; i < 16; i++)
        begin
            row[i] = (i == 0) ? 64'd1 : 64'd0;
        end
        for (int r = 1; r <= n; r++)
        begin
            for (int i = 15; i > 0; i--)
            begin
                row[i] = row[i] + row[i-1];
            end
        end
        return (k >= 0 && k < 16) ? row[k] : 64'd0;
    endfunction

endpackage

### hdl/btsmp_cell.sv
// One history cell: holds a point pair and computes its own Bernstein weight.
// Depends on btsmp_pkg for the pair type, control struct and widths.
module btsmp_cell
    import btsmp_pkg::*;
#(
    parameter int K = 0,
    parameter int HISTORY_POINTS = DEF_HISTORY,
    localparam int CW = $clog2(HISTORY_POINTS + 1),
    localparam int IW = $clog2(HISTORY_POINTS)
)
(
    input  logic                 clk,
    input  ctl_t                 ctl,
    input  logic [CW-1:0]        n,
    input  logic [CW-1:0]        step,
    input  logic signed [16:0]   u,
    input  logic signed [16:0]   d,
    input  pair_t                shift_in,
    input  pair_t                rot_in,
    input  logic signed [WW-1:0] rot_weight_in,
    output pair_t                data,
    output logic signed [WW-1:0] weight
);

    pair_t                 data_reg;
    logic signed [XW-1:0]  x_reg;
    logic signed [WW-1:0]  weight_reg;

    logic [XW-1:0]         coef_tab [HISTORY_POINTS];
    logic [CW:0]           pos;
    logic signed [16:0]    mul;
    logic signed [XW+16:0] prod;
    logic signed [XW+16:0] prod_rnd;
    logic signed [XW-1:0]  x_rnd;

    for (genvar m = 0; m < HISTORY_POINTS; m++)
    begin : g_coef
        assign coef_tab[m] = XW'(binom(m, K)) << 30;
    end

    // The first n-K steps multiply by (1-u), the remaining K steps by u.
    assign pos = {1'b0, step} + (CW+1)'(K);
    assign mul = (pos < {1'b0, n}) ? d : u;
    assign prod = x_reg * mul;
    assign prod_rnd = prod + (XW+17)'(1 << 13);
    assign x_rnd = x_reg + XW'(512);

    // Weights travel around the ring together with the data.
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            data_reg <= shift_in;
        end
        else if (ctl.rotate)
        begin
            data_reg <= rot_in;
        end

        if (ctl.wload)
        begin
            x_reg <= $signed(coef_tab[n[IW-1:0]]);
        end
        else if (ctl.wmul)
        begin
            x_reg <= prod_rnd[XW+13:14];
        end

        if (ctl.wfin)
        begin
            weight_reg <= x_rnd[WW+9:10];
        end
        else if (ctl.rotate)
        begin
            weight_reg <= rot_weight_in;
        end
    end

    assign data = data_reg;
    assign weight = weight_reg;

endmodule

### hdl/btsmp_mac.sv
// Six accumulation lanes (bottom and top x/y/z) with rounding and saturation.
// Depends on btsmp_pkg for the pair type and widths.
module btsmp_mac
    import btsmp_pkg::*;
(
    input  logic                 clk,
    input  logic                 clear,
    input  logic                 en,
    input  pair_t                data,
    input  logic signed [WW-1:0] weight,
    output pair_t                result
);

    logic signed [AW-1:0] acc_reg [6];

    for (genvar j = 0; j < 6; j++)
    begin : g_lane
        logic signed [WW+31:0] prod;
        logic signed [AW-1:0]  rnd;
        logic signed [AW-21:0] q;
        logic [31:0]           sat;

        assign prod = $signed(data[j]) * weight;
        assign rnd = acc_reg[j] + AW'(1 << 19);
        assign q = rnd[AW-1:20];

        always_ff @(posedge clk)
        begin
            if (clear)
            begin
                acc_reg[j] <= '0;
            end
            else if (en)
            begin
                acc_reg[j] <= acc_reg[j] + AW'(prod);
            end
        end

        always_comb
        begin
            if (q > (AW-20)'(32'sh7FFFFFFF))
            begin
                sat = 32'h7FFFFFFF;
            end
            else if (q < -(AW-20)'(33'sh080000000))
            begin
                sat = 32'h80000000;
            end
            else
            begin
                sat = q[31:0];
            end
        end

        assign result[j] = sat;
    end

endmodule

### hdl/bezier_trail_sampler_core.sv
// Bezier trail sampler: history ring of point-pair cells and a sample sequencer.
// Depends on btsmp_pkg, btsmp_cell and btsmp_mac.
// After an item is taken the sequencer passes S_DECIDE and offers the first result in S_EMIT;
// each further sample runs the weight steps (n = pairs held minus one), one full turn of the
// ring of H = HISTORY_POINTS cells, S_ROUND and S_EMIT; in_stall holds off new items till the last.
// Reset clears the pair count, the sequencer and min_points (to 2); history data is not reset.
module bezier_trail_sampler_core
    import btsmp_pkg::*;
#(
    parameter int HISTORY_POINTS = DEF_HISTORY,
    parameter int TRACE_SAMPLES = DEF_TRACE
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic signed [31:0] bottom_x,
    input  logic signed [31:0] bottom_y,
    input  logic signed [31:0] bottom_z,
    input  logic signed [31:0] top_x,
    input  logic signed [31:0] top_y,
    input  logic signed [31:0] top_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [5:0]         sample_index,
    output logic signed [31:0] curve_bottom_x,
    output logic signed [31:0] curve_bottom_y,
    output logic signed [31:0] curve_bottom_z,
    output logic signed [31:0] curve_top_x,
    output logic signed [31:0] curve_top_y,
    output logic signed [31:0] curve_top_z,
    output logic [14:0]        tex_u,
    output logic [7:0]         fade_alpha,
    output logic               visible,
    output logic               last
);

    localparam int CW = $clog2(HISTORY_POINTS + 1);
    localparam int RW = $clog2(HISTORY_POINTS);
    localparam int SW = $clog2(TRACE_SAMPLES);
    localparam int DEN = TRACE_SAMPLES - 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WLOAD,
        S_WSTEP,
        S_MAC,
        S_ROUND,
        S_EMIT
    } state_t;

    state_t               state_reg;
    logic [3:0]           min_points_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        step_reg;
    logic [RW-1:0]        rot_reg;
    logic [SW-1:0]        s_reg;

    logic [5:0]           sample_index_reg;
    pair_t                curve_reg;
    logic [14:0]          tex_u_reg;
    logic [7:0]           fade_alpha_reg;
    logic                 visible_reg;
    logic                 last_reg;

    logic signed [16:0]   u_tab [TRACE_SAMPLES];
    logic [7:0]           alpha_tab [TRACE_SAMPLES];

    for (genvar s = 0; s < TRACE_SAMPLES; s++)
    begin : g_utab
        localparam int UQ = ((s + 1) * 32768 + DEN) / (2 * DEN);
        localparam int AL = (UQ < U_ONE) ? (((U_ONE - UQ) * 255 + 8192) >> 14) : 0;
        assign u_tab[s] = 17'(UQ);
        assign alpha_tab[s] = 8'(AL);
    end

    ctl_t                 ctl;
    logic                 in_acc;
    logic [CW-1:0]        n;
    logic signed [16:0]   u_cur;
    logic signed [16:0]   d_cur;
    logic [3:0]           thr;
    pair_t                in_pair;
    pair_t                cell_data [HISTORY_POINTS];
    logic signed [WW-1:0] cell_weight [HISTORY_POINTS];
    pair_t                mac_result;
    logic                 mac_en;

    assign cfg_ready = 1'b1;
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc = in_valid && !in_stall;
    assign n = count_reg - CW'(1);
    assign u_cur = u_tab[s_reg];
    assign d_cur = 17'sd16384 - u_cur;
    assign thr = (min_points_reg == 4'd0) ? 4'd1 : min_points_reg;

    assign in_pair[0] = bottom_x;
    assign in_pair[1] = bottom_y;
    assign in_pair[2] = bottom_z;
    assign in_pair[3] = top_x;
    assign in_pair[4] = top_y;
    assign in_pair[5] = top_z;

    always_comb
    begin
        ctl.shift  = in_acc && (opcode == OP_ADD);
        ctl.rotate = (state_reg == S_MAC);
        ctl.wload  = (state_reg == S_WLOAD);
        ctl.wmul   = (state_reg == S_WSTEP) && (step_reg != n);
        ctl.wfin   = (state_reg == S_WSTEP) && (step_reg == n);
    end

    // The ring turns once per sample; entry k reaches cell 0 at turn k.
    assign mac_en = (state_reg == S_MAC) && ({1'b0, rot_reg} < (RW+1)'(count_reg));

    for (genvar i = 0; i < HISTORY_POINTS; i++)
    begin : g_cell
        btsmp_cell #(
            .K(i),
            .HISTORY_POINTS(HISTORY_POINTS)
        ) u_cell (
            .clk          (clk),
            .ctl          (ctl),
            .n            (n),
            .step         (step_reg),
            .u            (u_cur),
            .d            (d_cur),
            .shift_in     ((i == 0) ? in_pair
                                    : cell_data[(i + HISTORY_POINTS - 1) % HISTORY_POINTS]),
            .rot_in       (cell_data[(i + 1) % HISTORY_POINTS]),
            .rot_weight_in(cell_weight[(i + 1) % HISTORY_POINTS]),
            .data         (cell_data[i]),
            .weight       (cell_weight[i])
        );
    end

    btsmp_mac u_mac (
        .clk   (clk),
        .clear (state_reg == S_WLOAD),
        .en    (mac_en),
        .data  (cell_data[0]),
        .weight(cell_weight[0]),
        .result(mac_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_points_reg <= MIN_POINTS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            min_points_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            step_reg <= '0;
            rot_reg <= '0;
            s_reg <= '0;
            sample_index_reg <= '0;
            curve_reg <= '0;
            tex_u_reg <= '0;
            fade_alpha_reg <= '0;
            visible_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (opcode == OP_CLEAR)
                        begin
                            count_reg <= '0;
                        end
                        else if (count_reg != CW'(HISTORY_POINTS))
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    s_reg <= '0;
                    sample_index_reg <= '0;
                    tex_u_reg <= '0;
                    if (5'(count_reg) < 5'(thr))
                    begin
                        curve_reg <= '0;
                        fade_alpha_reg <= '0;
                        visible_reg <= 1'b0;
                        last_reg <= 1'b1;
                    end
                    else
                    begin
                        curve_reg <= cell_data[0];
                        fade_alpha_reg <= 8'd255;
                        visible_reg <= 1'b1;
                        last_reg <= 1'b0;
                    end
                    state_reg <= S_EMIT;
                end
                S_WLOAD:
                begin
                    step_reg <= '0;
                    state_reg <= S_WSTEP;
                end
                S_WSTEP:
                begin
                    if (step_reg == n)
                    begin
                        rot_reg <= '0;
                        state_reg <= S_MAC;
                    end
                    else
                    begin
                        step_reg <= step_reg + CW'(1);
                    end
                end
                S_MAC:
                begin
                    if (rot_reg == RW'(HISTORY_POINTS - 1))
                    begin
                        state_reg <= S_ROUND;
                    end
                    else
                    begin
                        rot_reg <= rot_reg + RW'(1);
                    end
                end
                S_ROUND:
                begin
                    sample_index_reg <= 6'(s_reg);
                    curve_reg <= mac_result;
                    tex_u_reg <= u_cur[14:0];
                    fade_alpha_reg <= alpha_tab[s_reg];
                    visible_reg <= 1'b1;
                    last_reg <= (s_reg == SW'(TRACE_SAMPLES - 1));
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!out_stall)
                    begin
                        if (last_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            s_reg <= s_reg + SW'(1);
                            state_reg <= S_WLOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = (state_reg == S_EMIT);
    assign sample_index = sample_index_reg;
    assign curve_bottom_x = curve_reg[0];
    assign curve_bottom_y = curve_reg[1];
    assign curve_bottom_z = curve_reg[2];
    assign curve_top_x = curve_reg[3];
    assign curve_top_y = curve_reg[4];
    assign curve_top_z = curve_reg[5];
    assign tex_u = tex_u_reg;
    assign fade_alpha = fade_alpha_reg;
    assign visible = visible_reg;
    assign last = last_reg;

endmodule

### hdl/btsmp_checker.sv
// Port-level checks for the Bezier trail sampler, bound to the top level.
// Depends only on the ports of bezier_trail_sampler_core.
module btsmp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [5:0]  sample_index,
    input logic [14:0] tex_u,
    input logic [7:0]  fade_alpha,
    input logic        visible,
    input logic        last
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // No result is offered in the cycle right after an item is taken.
    a_decide_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
        else $error("result offered before the item was evaluated");

    // A hidden trail is a single final beat with zero parameter and alpha.
    a_hidden: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !visible |-> last && tex_u == 15'd0 && fade_alpha == 8'd0)
        else $error("hidden result malformed");

    // The first visible sample is the newest pair at full alpha.
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && visible && sample_index == 6'd0 |-> fade_alpha == 8'd255 && tex_u == 15'd0)
        else $error("first sample malformed");

endmodule

bind bezier_trail_sampler_core btsmp_checker u_btsmp_checker (.*);
